// File: rtl/cced_pkg.sv
// shared constants, types and helpers of the control change event detector
package cced_pkg;

    localparam int BUTTON_COUNT = 64;
    localparam int AXIS_COUNT   = 16;

    localparam int IDX_W     = 6;
    localparam int RAW_W     = 17;
    localparam int VAL_W     = 16;
    localparam int TIME_W    = 32;
    localparam int GAIN_W    = 21;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 21;

    localparam int CORR_SHIFT = 14;
    localparam int SAT_MAX    = 32767;
    localparam int DIFF_W     = RAW_W + 1;
    localparam int PROD_W     = GAIN_W + DIFF_W;
    localparam int SHIFTED_W  = PROD_W - CORR_SHIFT;

    localparam int IDX_SPAN   = 2 ** IDX_W;
    localparam int BTN_DEPTH  = (BUTTON_COUNT < IDX_SPAN) ? BUTTON_COUNT : IDX_SPAN;
    localparam int AXIS_DEPTH = (AXIS_COUNT < IDX_SPAN) ? AXIS_COUNT : IDX_SPAN;
    localparam int BTN_AW     = (BTN_DEPTH > 1) ? $clog2(BTN_DEPTH) : 1;
    localparam int AXIS_AW    = (AXIS_DEPTH > 1) ? $clog2(AXIS_DEPTH) : 1;
    localparam int RANGE_W    = IDX_W + 3;

    localparam logic [CFG_IDX_W-1:0] REG_CORR_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRECISION = 3'd5;

    localparam logic [KIND_W-1:0] KIND_PASS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;

    localparam logic MODE_BUTTON = 1'b0;
    localparam logic MODE_AXIS   = 1'b1;

    typedef struct packed {
        logic                    en;
        logic                    mode;
        logic [IDX_W-1:0]        idx;
        logic signed [RAW_W-1:0] raw;
    } mem_wr_t;

    function automatic logic btn_in_range(input logic [IDX_W-1:0] idx);
        return {3'b000, idx} < RANGE_W'(BUTTON_COUNT);
    endfunction

    function automatic logic axis_in_range(input logic [IDX_W-1:0] idx);
        return {3'b000, idx} < RANGE_W'(AXIS_COUNT);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_value(
        input logic signed [SHIFTED_W-1:0] r
    );
        logic signed [SHIFTED_W-1:0] hi;
        logic signed [SHIFTED_W-1:0] lo;
        logic signed [VAL_W-1:0]     res;
        hi = SHIFTED_W'(SAT_MAX);
        lo = -hi;
        if (r > hi) begin
            res = hi[VAL_W-1:0];
        end else if (r < lo) begin
            res = lo[VAL_W-1:0];
        end else begin
            res = r[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/cced_state_mem.sv
// button level and axis raw value memories with per-entry valid bits
module cced_state_mem
    import cced_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_en,
    input  logic                    rd_mode,
    input  logic [IDX_W-1:0]        rd_idx,
    input  mem_wr_t                 wr,
    output logic signed [RAW_W-1:0] rd_raw
);

    logic                    btn_mem [BTN_DEPTH];
    logic signed [RAW_W-1:0] axis_mem [AXIS_DEPTH];

    logic [BTN_DEPTH-1:0]  btn_vld_reg;
    logic [AXIS_DEPTH-1:0] axis_vld_reg;

    logic                    btn_rd_reg;
    logic                    btn_rd_vld_reg;
    logic signed [RAW_W-1:0] axis_rd_reg;
    logic                    axis_rd_vld_reg;
    logic                    rd_mode_reg;

    logic [BTN_AW-1:0]  btn_ra;
    logic [AXIS_AW-1:0] axis_ra;
    logic [BTN_AW-1:0]  btn_wa;
    logic [AXIS_AW-1:0] axis_wa;
    logic               btn_we;
    logic               axis_we;

    assign btn_ra  = btn_in_range(rd_idx) ? BTN_AW'(rd_idx) : '0;
    assign axis_ra = axis_in_range(rd_idx) ? AXIS_AW'(rd_idx) : '0;
    assign btn_wa  = BTN_AW'(wr.idx);
    assign axis_wa = AXIS_AW'(wr.idx);
    assign btn_we  = wr.en && (wr.mode == MODE_BUTTON) && btn_in_range(wr.idx);
    assign axis_we = wr.en && (wr.mode == MODE_AXIS) && axis_in_range(wr.idx);

    always_ff @(posedge aclk) begin
        if (btn_we) begin
            btn_mem[btn_wa] <= wr.raw[0];
        end
        if (axis_we) begin
            axis_mem[axis_wa] <= wr.raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            btn_vld_reg  <= '0;
            axis_vld_reg <= '0;
        end else begin
            if (btn_we) begin
                btn_vld_reg[btn_wa] <= 1'b1;
            end
            if (axis_we) begin
                axis_vld_reg[axis_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            btn_rd_reg      <= btn_mem[btn_ra];
            btn_rd_vld_reg  <= btn_vld_reg[btn_ra];
            axis_rd_reg     <= axis_mem[axis_ra];
            axis_rd_vld_reg <= axis_vld_reg[axis_ra];
            rd_mode_reg     <= rd_mode;
        end
    end

    always_comb begin
        if (rd_mode_reg == MODE_AXIS) begin
            rd_raw = axis_rd_vld_reg ? axis_rd_reg : '0;
        end else begin
            rd_raw = {{(RAW_W-1){1'b0}}, btn_rd_vld_reg & btn_rd_reg};
        end
    end

endmodule

// File: rtl/cced_corrector.sv
// two-stage broken-line axis correction with saturation
module cced_corrector
    import cced_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic [KIND_W-1:0]        corr_kind,
    input  logic signed [RAW_W-1:0]  dead_low,
    input  logic signed [RAW_W-1:0]  dead_high,
    input  logic signed [GAIN_W-1:0] gain_low,
    input  logic signed [GAIN_W-1:0] gain_high,
    input  logic signed [RAW_W-1:0]  value_in,
    output logic signed [VAL_W-1:0]  corr_out
);

    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_PASS = 2'd1;
    localparam logic [1:0] SEL_MUL  = 2'd2;

    logic [1:0]               sel1_next;
    logic signed [GAIN_W-1:0] gain1_next;
    logic signed [DIFF_W-1:0] diff1_next;
    logic signed [DIFF_W-1:0] v_ext;

    logic [1:0]               sel1_reg;
    logic signed [RAW_W-1:0]  pass1_reg;
    logic signed [GAIN_W-1:0] gain1_reg;
    logic signed [DIFF_W-1:0] diff1_reg;

    logic signed [PROD_W-1:0] g_ext;
    logic signed [PROD_W-1:0] d_ext;
    logic signed [PROD_W-1:0] prod2_next;

    logic [1:0]               sel2_reg;
    logic signed [RAW_W-1:0]  pass2_reg;
    logic signed [PROD_W-1:0] prod2_reg;

    logic signed [SHIFTED_W-1:0] shifted;
    logic signed [SHIFTED_W-1:0] pass_ext;

    assign v_ext = {value_in[RAW_W-1], value_in};

    always_comb begin
        sel1_next  = SEL_ZERO;
        gain1_next = gain_low;
        diff1_next = v_ext - {dead_low[RAW_W-1], dead_low};
        if (corr_kind == KIND_PASS) begin
            sel1_next = SEL_PASS;
        end else if (corr_kind == KIND_LINE) begin
            if (value_in > dead_low) begin
                if (value_in < dead_high) begin
                    sel1_next = SEL_ZERO;
                end else begin
                    sel1_next  = SEL_MUL;
                    gain1_next = gain_high;
                    diff1_next = v_ext - {dead_high[RAW_W-1], dead_high};
                end
            end else begin
                sel1_next = SEL_MUL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel1_reg  <= sel1_next;
            pass1_reg <= value_in;
            gain1_reg <= gain1_next;
            diff1_reg <= diff1_next;
        end
    end

    assign g_ext      = PROD_W'(gain1_reg);
    assign d_ext      = PROD_W'(diff1_reg);
    assign prod2_next = g_ext * d_ext;

    always_ff @(posedge aclk) begin
        if (en) begin
            sel2_reg  <= sel1_reg;
            pass2_reg <= pass1_reg;
            prod2_reg <= prod2_next;
        end
    end

    assign shifted  = prod2_reg[PROD_W-1:CORR_SHIFT];
    assign pass_ext = SHIFTED_W'(pass2_reg);

    always_comb begin
        unique case (sel2_reg)
            SEL_PASS: corr_out = sat_value(pass_ext);
            SEL_MUL:  corr_out = sat_value(shifted);
            default:  corr_out = '0;
        endcase
    end

endmodule

// File: rtl/control_change_event_detector.sv
// top level: config registers, state read-modify-write pipeline and event output
//
// Takes one control sample per cycle while the output is not stalled; each sample
// is registered through stages s1, s2 and s3 and then the output register. The
// stored button levels and axis raw values sit in small synchronous memories
// read when a sample is accepted; the third stage decides the event and writes
// back, and the last three write-backs are forwarded to younger samples of the
// same control. Two correction pipelines (new and stored raw value) each hold
// one registered 21 x 18 multiply. After reset all stored values read as zero
// at once. Configuration may only be written while no sample is in flight.
module control_change_event_detector
    import cced_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,   // control_index, raw_value, tick_time, pad
    input  logic                  s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // event_number, event_value, event_time, pad
    output logic                  m_tuser,   // event_kind
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef struct packed {
        logic                    vld;
        logic                    mode;
        logic [IDX_W-1:0]        idx;
        logic signed [RAW_W-1:0] raw;
        logic signed [VAL_W-1:0] corr;
    } hist_t;

    logic [KIND_W-1:0]        corr_kind_reg;
    logic signed [RAW_W-1:0]  dead_low_reg;
    logic signed [RAW_W-1:0]  dead_high_reg;
    logic signed [GAIN_W-1:0] gain_low_reg;
    logic signed [GAIN_W-1:0] gain_high_reg;
    logic signed [RAW_W-1:0]  precision_reg;

    logic adv;
    logic accept;

    logic [IDX_W-1:0]        in_idx;
    logic signed [RAW_W-1:0] in_raw;
    logic [TIME_W-1:0]       in_time;

    logic                    s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic                    s1_mode_reg, s2_mode_reg, s3_mode_reg;
    logic [IDX_W-1:0]        s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [RAW_W-1:0] s1_raw_reg, s2_raw_reg, s3_raw_reg;
    logic [TIME_W-1:0]       s1_time_reg, s2_time_reg, s3_time_reg;
    logic signed [RAW_W-1:0] s2_cur_reg, s3_cur_reg;

    logic signed [RAW_W-1:0] rd_raw;
    logic signed [VAL_W-1:0] corr_new;
    logic signed [VAL_W-1:0] corr_cur;

    hist_t h0_reg, h1_reg, h2_reg;
    hist_t h0_next;

    logic signed [RAW_W-1:0]  cur_raw;
    logic signed [VAL_W-1:0]  cur_corr;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        abs_diff;
    logic                     prec_all;
    logic                     change_big;
    logic                     btn_emit;
    logic                     axis_emit;
    logic                     emit;
    mem_wr_t                  mem_wr;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    m_kind_reg;
    logic [IDX_W-1:0]        m_number_reg;
    logic signed [VAL_W-1:0] m_value_reg, m_value_next;
    logic [TIME_W-1:0]       m_time_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_raw  = s_tdata[IDX_W+RAW_W-1:IDX_W];
    assign in_time = s_tdata[IDX_W+RAW_W+TIME_W-1:IDX_W+RAW_W];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_kind_reg <= KIND_PASS;
            dead_low_reg  <= '0;
            dead_high_reg <= '0;
            gain_low_reg  <= GAIN_W'(16384);
            gain_high_reg <= GAIN_W'(16384);
            precision_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CORR_KIND: corr_kind_reg <= cfg_wdata[KIND_W-1:0];
                REG_DEAD_LOW:  dead_low_reg  <= cfg_wdata[RAW_W-1:0];
                REG_DEAD_HIGH: dead_high_reg <= cfg_wdata[RAW_W-1:0];
                REG_GAIN_LOW:  gain_low_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_HIGH: gain_high_reg <= cfg_wdata[GAIN_W-1:0];
                REG_PRECISION: precision_reg <= cfg_wdata[RAW_W-1:0];
                default: ;
            endcase
        end
    end

    cced_state_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_mode (s_tuser),
        .rd_idx  (in_idx),
        .wr      (mem_wr),
        .rd_raw  (rd_raw)
    );

    cced_corrector u_corr_new (
        .aclk      (aclk),
        .en        (adv),
        .corr_kind (corr_kind_reg),
        .dead_low  (dead_low_reg),
        .dead_high (dead_high_reg),
        .gain_low  (gain_low_reg),
        .gain_high (gain_high_reg),
        .value_in  (s1_raw_reg),
        .corr_out  (corr_new)
    );

    cced_corrector u_corr_cur (
        .aclk      (aclk),
        .en        (adv),
        .corr_kind (corr_kind_reg),
        .dead_low  (dead_low_reg),
        .dead_high (dead_high_reg),
        .gain_low  (gain_low_reg),
        .gain_high (gain_high_reg),
        .value_in  (rd_raw),
        .corr_out  (corr_cur)
    );

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_mode_reg <= s_tuser;
            s1_idx_reg  <= in_idx;
            s1_raw_reg  <= in_raw;
            s1_time_reg <= in_time;
            s2_mode_reg <= s1_mode_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_raw_reg  <= s1_raw_reg;
            s2_time_reg <= s1_time_reg;
            s2_cur_reg  <= rd_raw;
            s3_mode_reg <= s2_mode_reg;
            s3_idx_reg  <= s2_idx_reg;
            s3_raw_reg  <= s2_raw_reg;
            s3_time_reg <= s2_time_reg;
            s3_cur_reg  <= s2_cur_reg;
        end
    end

    // forwarding from write-backs newer than the memory read
    always_comb begin
        cur_raw  = s3_cur_reg;
        cur_corr = corr_cur;
        priority if (h0_reg.vld && h0_reg.mode == s3_mode_reg && h0_reg.idx == s3_idx_reg) begin
            cur_raw  = h0_reg.raw;
            cur_corr = h0_reg.corr;
        end else if (h1_reg.vld && h1_reg.mode == s3_mode_reg
                     && h1_reg.idx == s3_idx_reg) begin
            cur_raw  = h1_reg.raw;
            cur_corr = h1_reg.corr;
        end else if (h2_reg.vld && h2_reg.mode == s3_mode_reg
                     && h2_reg.idx == s3_idx_reg) begin
            cur_raw  = h2_reg.raw;
            cur_corr = h2_reg.corr;
        end
    end

    // event decision
    assign diff       = {s3_raw_reg[RAW_W-1], s3_raw_reg} - {cur_raw[RAW_W-1], cur_raw};
    assign abs_diff   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign prec_all   = (precision_reg == -RAW_W'(1));
    assign change_big = $signed({1'b0, abs_diff})
                        > $signed({{2{precision_reg[RAW_W-1]}}, precision_reg});
    assign btn_emit   = btn_in_range(s3_idx_reg) && (s3_raw_reg[0] != cur_raw[0]);
    assign axis_emit  = axis_in_range(s3_idx_reg)
                        && ((prec_all && corr_new != '0)
                            || (change_big && corr_new != cur_corr));
    assign emit       = s3_vld_reg
                        && ((s3_mode_reg == MODE_AXIS) ? axis_emit : btn_emit);

    assign mem_wr.en   = adv && emit;
    assign mem_wr.mode = s3_mode_reg;
    assign mem_wr.idx  = s3_idx_reg;
    assign mem_wr.raw  = s3_raw_reg;

    assign h0_next.vld  = mem_wr.en;
    assign h0_next.mode = s3_mode_reg;
    assign h0_next.idx  = s3_idx_reg;
    assign h0_next.raw  = s3_raw_reg;
    assign h0_next.corr = corr_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h0_reg <= '0;
            h1_reg <= '0;
            h2_reg <= '0;
        end else if (adv) begin
            h0_reg <= h0_next;
            h1_reg <= h0_reg;
            h2_reg <= h1_reg;
        end
    end

    // output register
    assign m_tvalid_next = emit;
    assign m_value_next  = (s3_mode_reg == MODE_AXIS)
                           ? corr_new : {{(VAL_W-1){1'b0}}, s3_raw_reg[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_kind_reg   <= s3_mode_reg;
            m_number_reg <= s3_idx_reg;
            m_value_reg  <= m_value_next;
            m_time_reg   <= s3_time_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {2'b00, m_time_reg, m_value_reg, m_number_reg};

    a_axis_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == MODE_AXIS) |-> (m_tdata[21:6] != 16'h8000))
        else $error("axis event value outside saturation range");

    a_btn_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == MODE_BUTTON) |-> (m_tdata[21:7] == '0))
        else $error("button event value is not a level");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == MODE_AXIS) |-> axis_in_range(m_tdata[5:0]))
        else $error("axis event for an axis beyond the table");

    a_wr_source: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr.en |-> (s3_vld_reg && adv))
        else $error("state write without a sample in the decision stage");

    a_hist_track: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr.en |=> (h0_reg.vld && m_tvalid))
        else $error("write-back not matched by forwarding entry and event");

endmodule

// File: tb/control_change_event_detector_test.sv
// testbench of the control change event detector: queued samples, event predictor, beat checker
`timescale 1ns / 1ps

module control_change_event_detector_test;
    import cced_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 9;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int DRAIN_CYCLES     = 12;
    localparam int PHASE_ITEMS      = 176;
    localparam int RANDOM_PHASES    = 4;
    localparam int REPORT_MAX       = 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER  = 40;
    localparam int PRECISION_EVERY  = -1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [KIND_W-1:0]    KIND_ZERO_A = 2'd2;
    localparam logic [KIND_W-1:0]    KIND_ZERO_B = 2'd3;
    localparam logic                 EVENT_BUTTON = 1'b0;
    localparam logic                 EVENT_AXIS   = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic [IDX_W-1:0]        idx;
        logic signed [RAW_W-1:0] raw;
        logic [TIME_W-1:0]       ticks;
    } sample_t;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        number;
        logic signed [VAL_W-1:0] value;
        logic [TIME_W-1:0]       ticks;
    } event_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [55:0]           s_tdata   = '0;   // control_index, raw_value, tick_time, pad
    logic                  s_tuser   = 1'b0; // mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;          // event_number, event_value, event_time, pad
    logic                  m_tuser;          // event_kind
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of the registers and the stored control state
    logic [KIND_W-1:0]        corr_kind  = KIND_PASS;
    logic signed [RAW_W-1:0]  dz_low     = '0;
    logic signed [RAW_W-1:0]  dz_high    = '0;
    logic signed [GAIN_W-1:0] gain_low   = 21'sd16384;
    logic signed [GAIN_W-1:0] gain_high  = 21'sd16384;
    logic signed [RAW_W-1:0]  precision  = '0;
    logic [BUTTON_COUNT-1:0]  button_level = '0;
    logic signed [RAW_W-1:0]  axis_reported [AXIS_COUNT] = '{default: '0};

    logic signed [RAW_W-1:0]  last_sent_raw [IDX_SPAN] = '{default: '0};

    sample_t pending_samples[$];
    event_t  expected_events[$];
    sample_t offered;

    int burst_left     = 0;
    int gap_left       = 0;
    int stall_style    = 0;
    int style_left     = 0;
    int hold_left      = 0;
    int event_beats    = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    bit long_hold_done = 1'b0;

    control_change_event_detector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic logic signed [VAL_W-1:0] corrected(input logic signed [RAW_W-1:0] v);
        longint r;
        if (corr_kind == KIND_PASS) begin
            r = longint'(v);
        end else if (corr_kind == KIND_LINE) begin
            if (v > dz_low && v < dz_high) begin
                r = 0;
            end else if (v > dz_low) begin
                r = (longint'(gain_high) * (longint'(v) - longint'(dz_high))) >>> CORR_SHIFT;
            end else begin
                r = (longint'(gain_low) * (longint'(v) - longint'(dz_low))) >>> CORR_SHIFT;
            end
        end else begin
            r = 0;
        end
        if (r > SAT_MAX) begin
            r = SAT_MAX;
        end else if (r < -SAT_MAX) begin
            r = -SAT_MAX;
        end
        return VAL_W'(r);
    endfunction

    function automatic void predict_event(input sample_t s);
        logic signed [VAL_W-1:0] fresh;
        longint                  change;
        event_t                  ev;
        logic [AXIS_AW-1:0]      axis_slot;
        ev.number = s.idx;
        ev.ticks  = s.ticks;
        if (s.mode == MODE_BUTTON) begin
            if (s.idx >= BUTTON_COUNT || s.raw[0] == button_level[s.idx]) return;
            button_level[s.idx] = s.raw[0];
            ev.kind  = EVENT_BUTTON;
            ev.value = VAL_W'(s.raw[0]);
        end else begin
            if (s.idx >= AXIS_COUNT) return;
            axis_slot = AXIS_AW'(s.idx);
            fresh  = corrected(s.raw);
            change = longint'(s.raw) - longint'(axis_reported[axis_slot]);
            if (change < 0) change = -change;
            if (!((precision == PRECISION_EVERY && fresh != 0) ||
                  (change > longint'(precision) && fresh != corrected(axis_reported[axis_slot]))))
                return;
            axis_reported[axis_slot] = s.raw;
            ev.kind  = EVENT_AXIS;
            ev.value = fresh;
        end
        expected_events.push_back(ev);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && cfg_wr_en) begin
            case (cfg_addr)
                REG_CORR_KIND: corr_kind <= cfg_wdata[KIND_W-1:0];
                REG_DEAD_LOW:  dz_low    <= cfg_wdata[RAW_W-1:0];
                REG_DEAD_HIGH: dz_high   <= cfg_wdata[RAW_W-1:0];
                REG_GAIN_LOW:  gain_low  <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_HIGH: gain_high <= cfg_wdata[GAIN_W-1:0];
                REG_PRECISION: precision <= cfg_wdata[RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // sender: bursts of beats with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_event(offered);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    offered = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, offered.ticks, offered.raw, offered.idx};
                    s_tuser  <= offered.mode;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: changing stall styles, rare holds and one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(32, 256);
            end else begin
                style_left = style_left - 1;
            end
            if (hold_left == 0 && !long_hold_done && event_beats >= LONG_HOLD_AFTER) begin
                hold_left      = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end else if (hold_left == 0 && $urandom_range(0, 4095) == 0) begin
                hold_left = $urandom_range(50, 200);
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                case (stall_style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= style_left[2];
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        event_t got;
        event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            event_beats <= event_beats + 1;
            got.kind   = m_tuser;
            got.number = m_tdata[5:0];
            got.value  = m_tdata[21:6];
            got.ticks  = m_tdata[53:22];
            if (expected_events.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected event beat: kind %0d number %0d value %0d tick %h",
                             got.kind, got.number, got.value, got.ticks);
            end else begin
                want = expected_events.pop_front();
                if (got.kind !== want.kind || got.number !== want.number ||
                    got.value !== want.value || got.ticks !== want.ticks) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_MAX)
                        $display("event beat: expected kind %0d number %0d value %0d tick %h, %s",
                                 want.kind, want.number, want.value, want.ticks,
                                 $sformatf("got kind %0d number %0d value %0d tick %h",
                                           got.kind, got.number, got.value, got.ticks));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_sample(input logic mode, input logic [IDX_W-1:0] idx,
                                input logic signed [RAW_W-1:0] raw,
                                input logic [TIME_W-1:0] ticks);
        sample_t s;
        s.mode  = mode;
        s.idx   = idx;
        s.raw   = raw;
        s.ticks = ticks;
        pending_samples.push_back(s);
    endtask

    function automatic logic signed [RAW_W-1:0] pick_axis_raw(input logic [IDX_W-1:0] idx);
        int                      pick;
        logic signed [RAW_W-1:0] edge_raw;
        logic signed [RAW_W-1:0] v;
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
            v = RAW_W'($urandom);
        end else if (pick <= 4) begin
            edge_raw = $urandom_range(0, 1) ? dz_low : dz_high;
            v = RAW_W'(int'(edge_raw) + int'($urandom_range(0, 64)) - 32);
        end else if (pick <= 7) begin
            v = RAW_W'(int'(last_sent_raw[idx]) + int'($urandom_range(0, 600)) - 300);
        end else if (pick == 8) begin
            v = $urandom_range(0, 1) ? RAW_W'(65535) : RAW_W'(-65536);
        end else begin
            v = '0;
        end
        last_sent_raw[idx] = v;
        return v;
    endfunction

    task automatic queue_random(input int count);
        logic [IDX_W-1:0] idx;
        repeat (count) begin
            if ($urandom_range(0, 1) == 0) begin
                idx = IDX_W'($urandom_range(0, IDX_SPAN - 1));
                queue_sample(MODE_BUTTON, idx, RAW_W'($urandom), $urandom);
            end else begin
                idx = IDX_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, IDX_SPAN - 1)
                                                         : $urandom_range(0, AXIS_COUNT - 1));
                queue_sample(MODE_AXIS, idx, pick_axis_raw(idx), $urandom);
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
    endtask

    task automatic set_all(input logic [KIND_W-1:0] kind, input int dlo, input int dhi,
                           input int glo, input int ghi, input int prec);
        write_register(REG_CORR_KIND, CFG_DATA_W'(kind));
        write_register(REG_DEAD_LOW,  CFG_DATA_W'(dlo));
        write_register(REG_DEAD_HIGH, CFG_DATA_W'(dhi));
        write_register(REG_GAIN_LOW,  CFG_DATA_W'(glo));
        write_register(REG_GAIN_HIGH, CFG_DATA_W'(ghi));
        write_register(REG_PRECISION, CFG_DATA_W'(prec));
        write_register(REG_SPARE_A,   CFG_DATA_W'($urandom));
        write_register(REG_SPARE_B,   CFG_DATA_W'($urandom));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until every sample is taken and every event has come out, then let the pipe empty
    task automatic settle();
        @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase();
        queue_random(PHASE_ITEMS);
        settle();
    endtask

    initial begin
        int prec;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // pass through, precision zero
        queue_sample(MODE_AXIS,   6'd0,  17'sd65535,  32'h0000_0000);
        queue_sample(MODE_AXIS,   6'd0,  -17'sd65536, 32'hffff_ffff);
        queue_sample(MODE_AXIS,   6'd0,  -17'sd65536, 32'h5555_5555);
        queue_sample(MODE_AXIS,   6'd15, 17'sd1,      32'haaaa_aaaa);
        queue_sample(MODE_AXIS,   6'd15, 17'sd1,      32'h0000_0001);
        queue_sample(MODE_AXIS,   6'd16, 17'sd100,    32'h8000_0000);
        queue_sample(MODE_AXIS,   6'd63, -17'sd5,     32'h7fff_ffff);
        queue_sample(MODE_AXIS,   6'd1,  17'sd0,      32'h1234_5678);
        queue_sample(MODE_AXIS,   6'd1,  -17'sd1,     32'h0000_0002);
        queue_sample(MODE_BUTTON, 6'd0,  17'sd1,      32'h0000_0003);
        queue_sample(MODE_BUTTON, 6'd0,  17'sd3,      32'h0000_0004);
        queue_sample(MODE_BUTTON, 6'd0,  17'sd2,      32'h0000_0005);
        queue_sample(MODE_BUTTON, 6'd63, -17'sd1,     32'hffff_fffe);
        queue_sample(MODE_BUTTON, 6'd63, -17'sd65536, 32'hffff_fffd);
        queue_sample(MODE_BUTTON, 6'd63, 17'sd65535,  32'h0f0f_0f0f);
        queue_sample(MODE_BUTTON, 6'd31, 17'sd0,      32'hf0f0_f0f0);
        settle();
        run_phase();

        set_all(KIND_LINE, -1000, 1000, 16384, 16384, 10);
        run_phase();
        set_all(KIND_LINE, -65536, 65535, 1048575, -1048576, PRECISION_EVERY);
        run_phase();
        // dead zone edges crossed over, other negative precision
        set_all(KIND_LINE, 65535, -65536, -1048576, 1048575, -2);
        run_phase();
        set_all(KIND_ZERO_A, 0, 0, 16384, 16384, PRECISION_EVERY);
        run_phase();
        set_all(KIND_PASS, -300, 300, 8192, 32768, 65535);
        run_phase();
        set_all(KIND_ZERO_B, -20, 20, 16384, 16384, 0);
        run_phase();

        repeat (RANDOM_PHASES) begin
            case ($urandom_range(0, 3))
                0:       prec = PRECISION_EVERY;
                1:       prec = -int'($urandom_range(2, 65536));
                2:       prec = $urandom_range(0, 100);
                default: prec = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(0, 1) == 0)
                set_all(KIND_LINE, -int'($urandom_range(0, 4000)), $urandom_range(0, 4000),
                        int'(GAIN_W'($urandom)), int'(GAIN_W'($urandom)), prec);
            else
                set_all(KIND_W'($urandom), int'(RAW_W'($urandom)), int'(RAW_W'($urandom)),
                        int'(GAIN_W'($urandom)), int'(GAIN_W'($urandom)), prec);
            run_phase();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cced_pkg.sv
rtl/cced_state_mem.sv
rtl/cced_corrector.sv
rtl/control_change_event_detector.sv
tb/control_change_event_detector_test.sv
